/* rtl/atpc_pkg.sv */
// Shared types and constants for the two-point accelerometer calibration block.
package atpc_pkg;

    localparam int SCALE_FACTOR = 1024;
    localparam int COUNT_WIDTH  = 16;
    localparam int DATA_WIDTH   = 16;
    localparam int SUM_WIDTH    = 32;
    localparam int FS_WIDTH     = 5;
    localparam int NUM_AXES     = 3;
    localparam int NUM_PAIRS    = 2 * NUM_AXES;

    localparam logic [FS_WIDTH-1:0] FS_RESET = 5'd2;

    // Numerators of the positive and (negated) negative targets.
    localparam logic [SUM_WIDTH-1:0] YMAX_NUM = 32'd32767;
    localparam logic [SUM_WIDTH-1:0] YMIN_NUM = 32'd32768;

    localparam logic [1:0] KIND_CLEAR     = 2'd0;
    localparam logic [1:0] KIND_ACCUM     = 2'd1;
    localparam logic [1:0] KIND_CALIBRATE = 2'd2;
    localparam logic [1:0] KIND_CORRECT   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_EQUAL = 2'd2;

    typedef struct packed {
        logic [1:0]                    kind;
        logic [1:0]                    axis_sel;
        logic                          direction_sel;
        logic signed [DATA_WIDTH-1:0]  sample_x;
        logic signed [DATA_WIDTH-1:0]  sample_y;
        logic signed [DATA_WIDTH-1:0]  sample_z;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  corrected_x;
        logic signed [DATA_WIDTH-1:0]  corrected_y;
        logic signed [DATA_WIDTH-1:0]  corrected_z;
        logic                          calibrated;
        logic [1:0]                    status_code;
    } out_item_t;

endpackage

/* rtl/accel_two_point_calibration.sv */
// Two-point accelerometer calibration: accumulators, serial calibrate and sample correction.
// Clear and accumulate update the sums and counts in the dispatch state, then go to the output; correct
// uses one shared 18x18 multiplier once per axis; calibrate runs 14 divisions on a
// shared radix-2 divider, fewer on early failure.
// Throughput: one transaction at a time; the input is ready only while the sequencer idles.
// Reset: asynchronous active-low rst_n clears sums, counts, scale, bias, done flag and sets
// the full-scale register to 2.
module accel_two_point_calibration
    import atpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [FS_WIDTH-1:0]  cfg_wdata
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CAL  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_COR  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // Calibrate steps; each names the work done once its division (if any) has finished
    localparam logic [2:0] C_YMAX  = 3'd0;
    localparam logic [2:0] C_NMIN  = 3'd1;
    localparam logic [2:0] C_CHECK = 3'd2;
    localparam logic [2:0] C_AVP   = 3'd3;
    localparam logic [2:0] C_AVN   = 3'd4;
    localparam logic [2:0] C_SCALE = 3'd5;
    localparam logic [2:0] C_PROD  = 3'd6;
    localparam logic [2:0] C_BIAS  = 3'd7;

    localparam int DIV_STEPS = SUM_WIDTH;
    localparam int DIV_CW    = $clog2(DIV_STEPS);
    localparam int DEN_W     = DATA_WIDTH + 1;
    localparam int MUL_W     = DATA_WIDTH + 2;
    localparam int PROD_W    = 2 * MUL_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic signed [PROD_W-1:0] Sf_div = PROD_W'(SCALE_FACTOR);
    localparam logic [1:0] LAST_AXIS = 2'(NUM_AXES - 1);

    // Architectural state
    logic signed [SUM_WIDTH-1:0]  sums_reg   [NUM_PAIRS];
    logic signed [SUM_WIDTH-1:0]  sums_next  [NUM_PAIRS];
    logic [COUNT_WIDTH-1:0]       counts_reg [NUM_PAIRS];
    logic [COUNT_WIDTH-1:0]       counts_next[NUM_PAIRS];
    logic signed [DATA_WIDTH-1:0] scale_reg  [NUM_AXES];
    logic signed [DATA_WIDTH-1:0] scale_next [NUM_AXES];
    logic signed [DATA_WIDTH-1:0] bias_reg   [NUM_AXES];
    logic signed [DATA_WIDTH-1:0] bias_next  [NUM_AXES];
    logic                         done_reg, done_next;
    logic [FS_WIDTH-1:0]          fs_reg, fs_next;

    // Sequencer and working registers
    logic [2:0]                   state_reg, state_next;
    logic [2:0]                   step_reg, step_next;
    logic [1:0]                   axis_reg, axis_next;
    in_item_t                     item_reg, item_next;
    logic [DATA_WIDTH-1:0]        ymax_reg, ymax_next;
    logic [DEN_W-1:0]             span_reg, span_next;
    logic signed [DATA_WIDTH-1:0] avp_reg, avp_next;
    logic signed [DATA_WIDTH-1:0] xmax_reg, xmax_next;
    logic [DEN_W-1:0]             dx_reg, dx_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [DATA_WIDTH-1:0] res_reg [NUM_AXES];
    logic signed [DATA_WIDTH-1:0] res_next[NUM_AXES];
    logic [1:0]                   status_reg, status_next;

    // Shared divider
    logic [DEN_W-1:0]             div_rem_reg, div_rem_next;
    logic [SUM_WIDTH-1:0]         div_quo_reg, div_quo_next;
    logic [DEN_W-1:0]             div_den_reg, div_den_next;
    logic [DIV_CW-1:0]            div_cnt_reg, div_cnt_next;
    logic                         div_neg_reg, div_neg_next;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    out_item_t                    out_data_reg, out_data_next;

    // Combinational helpers
    logic [DEN_W:0]               div_shift;
    logic [DATA_WIDTH-1:0]        div_signed;
    logic signed [MUL_W-1:0]      mul_a, mul_b;
    logic signed [PROD_W-1:0]     mul_p;
    logic signed [PROD_W-1:0]     cor_t;
    logic [DEN_W-1:0]             range_w;
    logic                         div_start;
    logic [SUM_WIDTH-1:0]         div_dvd;
    logic [DEN_W-1:0]             div_dsr;
    logic                         div_sgn;
    logic [2:0]                   acc_idx;
    logic signed [DATA_WIDTH-1:0] acc_sample;
    logic signed [DATA_WIDTH-1:0] cor_sample;
    logic signed [DATA_WIDTH-1:0] avn_w;
    logic [COUNT_WIDTH-1:0]       cp_w, cn_w;
    logic signed [SUM_WIDTH-1:0]  sp_w, sn_w;
    logic [PROD_W-1:0]            prod_mag;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Full scale of zero counts as one
    assign range_w = (fs_reg == '0) ? DEN_W'(1) : DEN_W'(fs_reg);

    // Divider datapath: one quotient bit per cycle
    assign div_shift  = {div_rem_reg, div_quo_reg[SUM_WIDTH-1]};
    assign div_signed = div_neg_reg ? (DATA_WIDTH'(0) - div_quo_reg[DATA_WIDTH-1:0])
                                    : div_quo_reg[DATA_WIDTH-1:0];

    // Shared multiplier: sample times scale when correcting, xmax times span when calibrating
    always_comb
    begin
        case (axis_reg)
            2'd0:    cor_sample = item_reg.sample_x;
            2'd1:    cor_sample = item_reg.sample_y;
            default: cor_sample = item_reg.sample_z;
        endcase
        if (state_reg == S_MUL)
        begin
            mul_a = MUL_W'(cor_sample);
            mul_b = MUL_W'(scale_reg[axis_reg]);
        end
        else
        begin
            mul_a = MUL_W'(xmax_reg);
            mul_b = $signed({1'b0, span_reg});
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign cor_t    = prod_reg / Sf_div;
    assign prod_mag = prod_reg[PROD_W-1] ? (PROD_W'(0) - prod_reg) : prod_reg;

    assign cp_w   = counts_reg[{1'b0, axis_reg}];
    assign cn_w   = counts_reg[3'({1'b0, axis_reg}) + 3'(NUM_AXES)];
    assign sp_w   = sums_reg[{1'b0, axis_reg}];
    assign sn_w   = sums_reg[3'({1'b0, axis_reg}) + 3'(NUM_AXES)];
    assign avn_w  = $signed(div_signed);

    // Accumulate target pair and sample
    always_comb
    begin
        acc_idx = item_reg.direction_sel ? (3'(NUM_AXES) + 3'(item_reg.axis_sel))
                                         : 3'(item_reg.axis_sel);
        case (item_reg.axis_sel)
            2'd0:    acc_sample = item_reg.sample_x;
            2'd1:    acc_sample = item_reg.sample_y;
            default: acc_sample = item_reg.sample_z;
        endcase
    end

    always_comb
    begin
        sums_next      = sums_reg;
        counts_next    = counts_reg;
        scale_next     = scale_reg;
        bias_next      = bias_reg;
        done_next      = done_reg;
        fs_next        = fs_reg;
        state_next     = state_reg;
        step_next      = step_reg;
        axis_next      = axis_reg;
        item_next      = item_reg;
        ymax_next      = ymax_reg;
        span_next      = span_reg;
        avp_next       = avp_reg;
        xmax_next      = xmax_reg;
        dx_next        = dx_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        div_neg_next   = div_neg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        div_dvd        = '0;
        div_dsr        = '0;
        div_sgn        = 1'b0;

        if (cfg_we)
        begin
            fs_next = cfg_wdata;
        end

        // Drop the held result once taken
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                status_next = STATUS_OK;
                axis_next   = '0;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    res_next[i] = '0;
                end
                case (item_reg.kind)
                    KIND_CLEAR:
                    begin
                        for (int i = 0; i < NUM_PAIRS; i++)
                        begin
                            sums_next[i]   = '0;
                            counts_next[i] = '0;
                        end
                        state_next = S_OUT;
                    end
                    KIND_ACCUM:
                    begin
                        if ((item_reg.axis_sel != 2'd3) && (counts_reg[acc_idx] != COUNT_MAX))
                        begin
                            sums_next[acc_idx]   = sums_reg[acc_idx] + SUM_WIDTH'(acc_sample);
                            counts_next[acc_idx] = counts_reg[acc_idx] + COUNT_WIDTH'(1);
                        end
                        state_next = S_OUT;
                    end
                    KIND_CALIBRATE:
                    begin
                        div_start = 1'b1;
                        div_dvd   = YMAX_NUM;
                        div_dsr   = range_w;
                        step_next = C_YMAX;
                    end
                    default:
                    begin
                        state_next = S_MUL;
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_shift >= {1'b0, div_den_reg})
                begin
                    div_rem_next = DEN_W'(div_shift - {1'b0, div_den_reg});
                    div_quo_next = {div_quo_reg[SUM_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = div_shift[DEN_W-1:0];
                    div_quo_next = {div_quo_reg[SUM_WIDTH-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIV_CW'(1);
                if (div_cnt_reg == DIV_CW'(DIV_STEPS - 1))
                begin
                    state_next = S_CAL;
                end
            end

            S_CAL:
            begin
                case (step_reg)
                    C_YMAX:
                    begin
                        ymax_next = div_quo_reg[DATA_WIDTH-1:0];
                        div_start = 1'b1;
                        div_dvd   = YMIN_NUM;
                        div_dsr   = range_w;
                        step_next = C_NMIN;
                    end
                    C_NMIN:
                    begin
                        span_next = DEN_W'(ymax_reg) + div_quo_reg[DEN_W-1:0];
                        step_next = C_CHECK;
                    end
                    C_CHECK:
                    begin
                        if ((cp_w == '0) || (cn_w == '0))
                        begin
                            status_next = STATUS_EMPTY;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            div_start = 1'b1;
                            div_dvd   = sp_w[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - sp_w) : sp_w;
                            div_dsr   = DEN_W'(cp_w);
                            div_sgn   = sp_w[SUM_WIDTH-1];
                            step_next = C_AVP;
                        end
                    end
                    C_AVP:
                    begin
                        avp_next  = $signed(div_signed);
                        div_start = 1'b1;
                        div_dvd   = sn_w[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - sn_w) : sn_w;
                        div_dsr   = DEN_W'(cn_w);
                        div_sgn   = sn_w[SUM_WIDTH-1];
                        step_next = C_AVN;
                    end
                    C_AVN:
                    begin
                        if (avn_w == avp_reg)
                        begin
                            status_next = STATUS_EQUAL;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            if (avp_reg > avn_w)
                            begin
                                xmax_next = avp_reg;
                                dx_next   = DEN_W'(DEN_W'(avp_reg) - DEN_W'(avn_w));
                            end
                            else
                            begin
                                xmax_next = avn_w;
                                dx_next   = DEN_W'(DEN_W'(avn_w) - DEN_W'(avp_reg));
                            end
                            div_start = 1'b1;
                            div_dvd   = SUM_WIDTH'(SCALE_FACTOR) * SUM_WIDTH'(span_reg);
                            div_dsr   = (avp_reg > avn_w)
                                      ? DEN_W'(DEN_W'(avp_reg) - DEN_W'(avn_w))
                                      : DEN_W'(DEN_W'(avn_w) - DEN_W'(avp_reg));
                            step_next = C_SCALE;
                        end
                    end
                    C_SCALE:
                    begin
                        scale_next[axis_reg] = $signed(div_quo_reg[DATA_WIDTH-1:0]);
                        prod_next            = mul_p;
                        step_next            = C_PROD;
                    end
                    C_PROD:
                    begin
                        div_start = 1'b1;
                        div_dvd   = prod_mag[SUM_WIDTH-1:0];
                        div_dsr   = dx_reg;
                        div_sgn   = prod_reg[PROD_W-1];
                        step_next = C_BIAS;
                    end
                    default:
                    begin
                        bias_next[axis_reg] = $signed(ymax_reg - div_signed);
                        if (axis_reg == LAST_AXIS)
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_OK;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                            step_next = C_CHECK;
                        end
                    end
                endcase
            end

            S_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_COR;
            end

            S_COR:
            begin
                res_next[axis_reg] = $signed(cor_t[DATA_WIDTH-1:0] + bias_reg[axis_reg]);
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_MUL;
                end
            end

            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.corrected_x = res_reg[0];
                    out_data_next.corrected_y = res_reg[1];
                    out_data_next.corrected_z = res_reg[2];
                    out_data_next.calibrated  = done_reg;
                    out_data_next.status_code = status_reg;
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Launch the shared divider
        if (div_start)
        begin
            div_rem_next = '0;
            div_quo_next = div_dvd;
            div_den_next = div_dsr;
            div_cnt_next = '0;
            div_neg_next = div_sgn;
            state_next   = S_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PAIRS; i++)
            begin
                sums_reg[i]   <= '0;
                counts_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_AXES; i++)
            begin
                scale_reg[i] <= '0;
                bias_reg[i]  <= '0;
            end
            done_reg      <= 1'b0;
            fs_reg        <= FS_RESET;
            state_reg     <= S_IDLE;
            step_reg      <= C_YMAX;
            axis_reg      <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sums_reg      <= sums_next;
            counts_reg    <= counts_next;
            scale_reg     <= scale_next;
            bias_reg      <= bias_next;
            done_reg      <= done_next;
            fs_reg        <= fs_next;
            state_reg     <= state_next;
            step_reg      <= step_next;
            axis_reg      <= axis_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        ymax_reg     <= ymax_next;
        span_reg     <= span_next;
        avp_reg      <= avp_next;
        xmax_reg     <= xmax_next;
        dx_reg       <= dx_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_den_reg  <= div_den_next;
        div_neg_reg  <= div_neg_next;
        out_data_reg <= out_data_next;
    end

endmodule
